// ===== src/assert_macros.svh =====
// Assertion macros for the checker file of this block.
// No dependencies; include once by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle, ignored while reset is held.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle, ignored while reset is held.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Implication checked in the next cycle, also active during reset.
`define ASSERT_NXT_RAW(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/mse_pkg.sv =====
// Types and constants of the execute unit: beat layouts, operation codes and
// register file port bundles. No dependencies.
`default_nettype none

package mse_pkg;

  localparam int unsigned IN_W        = 56;
  localparam int unsigned OUT_W       = 56;
  localparam int unsigned TARGET_BITS = 10;
  localparam logic [9:0]  TARGET_MASK = 10'((64'd1 << TARGET_BITS) - 64'd1);

  localparam logic [3:0] FN_NOP   = 4'd0;
  localparam logic [3:0] FN_ADD   = 4'd1;
  localparam logic [3:0] FN_SUB   = 4'd2;
  localparam logic [3:0] FN_AND   = 4'd3;
  localparam logic [3:0] FN_NOR   = 4'd4;
  localparam logic [3:0] FN_OR    = 4'd5;
  localparam logic [3:0] FN_XOR   = 4'd6;
  localparam logic [3:0] FN_LOAD  = 4'd7;
  localparam logic [3:0] FN_STORE = 4'd8;
  localparam logic [3:0] FN_BEQ   = 4'd9;
  localparam logic [3:0] FN_BNE   = 4'd10;
  localparam logic [3:0] FN_BGEZ  = 4'd11;
  localparam logic [3:0] FN_BGTZ  = 4'd12;
  localparam logic [3:0] FN_BLEZ  = 4'd13;

  localparam logic [1:0] BK_NONE = 2'd0;
  localparam logic [1:0] BK_BLTZ = 2'd1;
  localparam logic [1:0] BK_JUMP = 2'd2;

  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;

  typedef struct packed {
    logic [5:0]         pad;
    logic [9:0]         branch_target;
    logic [1:0]         access_size;
    logic signed [15:0] immediate;
    logic [4:0]         tgt_reg;
    logic [4:0]         src_reg;
    logic [4:0]         dest_reg;
    logic               use_immediate;
    logic [1:0]         branch_kind;
    logic [3:0]         func;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         pad;
    logic               mem_fault;
    logic signed [31:0] written_value;
    logic [4:0]         written_reg;
    logic               reg_written;
    logic [9:0]         jump_target;
    logic               jump_taken;
  } out_item_t;

  typedef struct packed {
    logic       en;
    logic [4:0] rs;
    logic [4:0] rt;
    logic [4:0] rd;
  } rf_rd_t;

  typedef struct packed {
    logic        en;
    logic [4:0]  idx;
    logic [31:0] data;
  } rf_wr_t;

endpackage

`default_nettype wire

// ===== src/mse_regfile.sv =====
// Register file held as two identical synchronous memories, giving three
// registered read ports and one write port. Depends on mse_pkg.
`default_nettype none

module mse_regfile (
  input  wire logic             clk,
  input  wire mse_pkg::rf_rd_t  rd_i,
  input  wire mse_pkg::rf_wr_t  wr_i,
  output logic [31:0]           rs_data_r,
  output logic [31:0]           rt_data_r,
  output logic [31:0]           rd_data_r
);

  logic [31:0] mem_a [32];
  logic [31:0] mem_b [32];

  always_ff @(posedge clk) begin
    if (wr_i.en) begin
      mem_a[wr_i.idx] <= wr_i.data;
      mem_b[wr_i.idx] <= wr_i.data;
    end
    if (rd_i.en) begin
      rs_data_r <= mem_a[rd_i.rs];
      rt_data_r <= mem_a[rd_i.rt];
      rd_data_r <= mem_b[rd_i.rd];
    end
  end

endmodule

`default_nettype wire

// ===== src/mse_datamem.sv =====
// Data memory split into four byte lanes, each a synchronous memory with one
// row access per cycle and a registered read. No dependencies.
`default_nettype none

module mse_datamem #(
  parameter int unsigned ROWS   = 1024,
  parameter int unsigned ROW_AW = 10
) (
  input  wire logic                        clk,
  input  wire logic                        rd_en_i,
  input  wire logic [3:0][ROW_AW-1:0]      row_i,
  input  wire logic [3:0]                  we_i,
  input  wire logic [3:0][7:0]             wdata_i,
  output logic [3:0][7:0]                  rdata_o
);

  for (genvar l = 0; l < 4; l++) begin : g_lane
    logic [7:0] bank_mem [ROWS];
    logic [7:0] q_r;

    always_ff @(posedge clk) begin
      if (we_i[l]) begin
        bank_mem[row_i[l]] <= wdata_i[l];
      end
      if (rd_en_i) begin
        q_r <= bank_mem[row_i[l]];
      end
    end

    assign rdata_o[l] = q_r;
  end

endmodule

`default_nettype wire

// ===== src/mips_subset_execute_unit.sv =====
// Execute unit: an input beat passes through stage 1, stage 2 and the output
// register to its result beat, and one instruction is accepted every cycle when
// the output is taken. Register reads happen in the accept cycle, data memory is
// accessed from stage 1 and register write-back occurs as the result enters the
// output register. After reset a clearing pass zeroes the memories; in_tready
// stays low until it ends. Depends on mse_pkg and submodules.
`default_nettype none

module mips_subset_execute_unit #(
  parameter int unsigned MEM_BYTES = 4096
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  // func, branch_kind, use_immediate, dest_reg, src_reg, tgt_reg, immediate,
  // access_size, branch_target, zero fill
  input  wire logic [mse_pkg::IN_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  // jump_taken, jump_target, reg_written, written_reg, written_value,
  // mem_fault, zero fill
  output logic [mse_pkg::OUT_W-1:0]       out_tdata
);

  localparam int unsigned ROWS   = (MEM_BYTES + 3) / 4;
  localparam int unsigned ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned CLR_N  = (ROWS > 32) ? ROWS : 32;
  localparam int unsigned CNT_W  = $clog2(CLR_N + 1);

  function automatic logic [31:0] fwd_sel(
    input logic [4:0]  idx,
    input logic [31:0] mem_q,
    input logic        s2_ok,
    input logic [4:0]  s2_idx,
    input logic [31:0] s2_data,
    input logic        wb_ok,
    input logic [4:0]  wb_idx,
    input logic [31:0] wb_data
  );
    logic [31:0] v;
    v = mem_q;
    if (s2_ok && s2_idx == idx) begin
      v = s2_data;
    end else if (wb_ok && wb_idx == idx) begin
      v = wb_data;
    end
    return v;
  endfunction

  mse_pkg::in_item_t  in_item;
  mse_pkg::out_item_t out_item_r;
  mse_pkg::out_item_t out_nxt;
  mse_pkg::rf_rd_t    rf_rd;
  mse_pkg::rf_wr_t    rf_wr;

  logic              accept;
  logic [4:0]        dst_in;
  logic [CNT_W-1:0]  clr_cnt_r;
  logic              clr_done_r;

  logic              s1_v_r;
  logic [3:0]        s1_func_r;
  logic [1:0]        s1_kind_r;
  logic              s1_useimm_r;
  logic [4:0]        s1_rs_r;
  logic [4:0]        s1_rt_r;
  logic [4:0]        s1_dst_r;
  logic [15:0]       s1_imm_r;
  logic [1:0]        s1_size_r;
  logic [9:0]        s1_target_r;

  logic              s2_v_r;
  logic              s2_taken_r;
  logic [9:0]        s2_target_r;
  logic              s2_wr_r;
  logic [4:0]        s2_dst_r;
  logic [31:0]       s2_alu_r;
  logic              s2_load_r;
  logic [1:0]        s2_size_r;
  logic [1:0]        s2_lo_r;
  logic              s2_fault_r;

  logic              out_v_r;
  logic              wb_v_r;
  logic [4:0]        wb_idx_r;
  logic [31:0]       wb_val_r;

  logic              s3_free;
  logic              s2_en;
  logic              s1_en;
  logic              item_wr;

  logic [31:0]       rs_q;
  logic [31:0]       rt_q;
  logic [31:0]       rd_q;
  logic [31:0]       op_a;
  logic [31:0]       op_t;
  logic [31:0]       st_data;
  logic [31:0]       op_b;
  logic [31:0]       sum;
  logic [2:0]        nbytes;
  logic [32:0]       end_addr;
  logic              is_mem;
  logic              fault_nxt;
  logic              load_nxt;
  logic              store_nxt;
  logic              taken_nxt;
  logic              wr_nxt;
  logic [31:0]       alu_nxt;

  logic [3:0]              lane_hit;
  logic [3:0][ROW_AW-1:0]  lane_row;
  logic [3:0][7:0]         lane_wdata;
  logic [3:0][ROW_AW-1:0]  dm_row;
  logic [3:0]              dm_we;
  logic [3:0][7:0]         dm_wdata;
  logic [3:0][7:0]         dm_rdata;

  logic [3:0][7:0]   ld_byte;
  logic [31:0]       load_val;
  logic [31:0]       s2_val;

  assign in_item   = mse_pkg::in_item_t'(in_tdata);
  assign s3_free   = !out_v_r || out_tready;
  assign s2_en     = !s2_v_r || s3_free;
  assign s1_en     = !s1_v_r || s2_en;
  assign in_tready = clr_done_r && s1_en;
  assign accept    = in_tvalid && in_tready;
  assign dst_in    = in_item.use_immediate ? in_item.tgt_reg : in_item.dest_reg;

  assign rf_rd.en = accept;
  assign rf_rd.rs = in_item.src_reg;
  assign rf_rd.rt = in_item.tgt_reg;
  assign rf_rd.rd = dst_in;

  assign item_wr = s3_free && s2_v_r && s2_wr_r;

  always_comb begin
    if (!clr_done_r) begin
      rf_wr.en   = (clr_cnt_r < CNT_W'(32));
      rf_wr.idx  = clr_cnt_r[4:0];
      rf_wr.data = '0;
    end else begin
      rf_wr.en   = item_wr;
      rf_wr.idx  = s2_dst_r;
      rf_wr.data = s2_val;
    end
  end

  mse_regfile u_regfile (
    .clk       (clk),
    .rd_i      (rf_rd),
    .wr_i      (rf_wr),
    .rs_data_r (rs_q),
    .rt_data_r (rt_q),
    .rd_data_r (rd_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      clr_done_r <= 1'b0;
    end else if (!clr_done_r) begin
      if (clr_cnt_r == CNT_W'(CLR_N - 1)) begin
        clr_done_r <= 1'b1;
      end else begin
        clr_cnt_r <= clr_cnt_r + CNT_W'(1);
      end
    end
  end

  // Operand fetch with forwarding from the write-back stage and the last write.
  always_comb begin
    op_a    = fwd_sel(s1_rs_r, rs_q, s2_v_r && s2_wr_r, s2_dst_r, s2_val,
                      wb_v_r, wb_idx_r, wb_val_r);
    op_t    = fwd_sel(s1_rt_r, rt_q, s2_v_r && s2_wr_r, s2_dst_r, s2_val,
                      wb_v_r, wb_idx_r, wb_val_r);
    st_data = fwd_sel(s1_dst_r, rd_q, s2_v_r && s2_wr_r, s2_dst_r, s2_val,
                      wb_v_r, wb_idx_r, wb_val_r);
    op_b    = s1_useimm_r ? {{16{s1_imm_r[15]}}, s1_imm_r} : op_t;
    sum     = op_a + op_b;
  end

  always_comb begin
    taken_nxt = 1'b0;
    wr_nxt    = 1'b0;
    alu_nxt   = '0;
    is_mem    = 1'b0;
    case (s1_kind_r)
      mse_pkg::BK_JUMP: begin
        taken_nxt = 1'b1;
      end
      mse_pkg::BK_BLTZ: begin
        taken_nxt = op_a[31];
      end
      default: begin
        case (s1_func_r)
          mse_pkg::FN_ADD: begin
            alu_nxt = sum;
            wr_nxt  = 1'b1;
          end
          mse_pkg::FN_SUB: begin
            alu_nxt = op_a - op_b;
            wr_nxt  = 1'b1;
          end
          mse_pkg::FN_AND: begin
            alu_nxt = op_a & op_b;
            wr_nxt  = 1'b1;
          end
          mse_pkg::FN_NOR: begin
            alu_nxt = ~(op_a | op_b);
            wr_nxt  = 1'b1;
          end
          mse_pkg::FN_OR: begin
            alu_nxt = op_a | op_b;
            wr_nxt  = 1'b1;
          end
          mse_pkg::FN_XOR: begin
            alu_nxt = op_a ^ op_b;
            wr_nxt  = 1'b1;
          end
          mse_pkg::FN_LOAD, mse_pkg::FN_STORE: begin
            is_mem = (s1_size_r == mse_pkg::SZ_BYTE) || (s1_size_r == mse_pkg::SZ_HALF)
                     || (s1_size_r == mse_pkg::SZ_WORD);
          end
          mse_pkg::FN_BEQ:  taken_nxt = (op_a == op_t);
          mse_pkg::FN_BNE:  taken_nxt = (op_a != op_t);
          mse_pkg::FN_BGEZ: taken_nxt = !op_a[31];
          mse_pkg::FN_BGTZ: taken_nxt = !op_a[31] && (op_a != '0);
          mse_pkg::FN_BLEZ: taken_nxt = op_a[31] || (op_a == '0);
          default: begin
          end
        endcase
      end
    endcase

    case (s1_size_r)
      mse_pkg::SZ_BYTE: nbytes = 3'd1;
      mse_pkg::SZ_HALF: nbytes = 3'd2;
      default:          nbytes = 3'd4;
    endcase
    end_addr  = {1'b0, sum} + 33'(nbytes);
    fault_nxt = is_mem && (end_addr > 33'(MEM_BYTES));
    load_nxt  = is_mem && !fault_nxt && (s1_func_r == mse_pkg::FN_LOAD);
    store_nxt = is_mem && !fault_nxt && (s1_func_r == mse_pkg::FN_STORE);
    if (load_nxt) begin
      wr_nxt = 1'b1;
    end
  end

  // Byte lane mapping: lane l carries byte (l - addr[1:0]) mod 4 of the access.
  for (genvar l = 0; l < 4; l++) begin : g_map
    logic [1:0] off;
    logic [2:0] lsum;

    assign off           = 2'(l) - sum[1:0];
    assign lsum          = {1'b0, sum[1:0]} + {1'b0, off};
    assign lane_hit[l]   = ({1'b0, off} < nbytes);
    assign lane_row[l]   = sum[ROW_AW+1:2] + ROW_AW'(lsum[2]);
    assign lane_wdata[l] = 8'(st_data >> {off, 3'b000});
  end

  always_comb begin
    if (!clr_done_r) begin
      for (int l = 0; l < 4; l++) begin
        dm_row[l] = clr_cnt_r[ROW_AW-1:0];
      end
      dm_we    = {4{clr_cnt_r < CNT_W'(ROWS)}};
      dm_wdata = '0;
    end else begin
      dm_row   = lane_row;
      dm_we    = (s2_en && s1_v_r && store_nxt) ? lane_hit : 4'b0000;
      dm_wdata = lane_wdata;
    end
  end

  mse_datamem #(
    .ROWS   (ROWS),
    .ROW_AW (ROW_AW)
  ) u_datamem (
    .clk     (clk),
    .rd_en_i (s2_en),
    .row_i   (dm_row),
    .we_i    (dm_we),
    .wdata_i (dm_wdata),
    .rdata_o (dm_rdata)
  );

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ld_byte[i] = dm_rdata[2'(s2_lo_r + 2'(i))];
    end
    case (s2_size_r)
      mse_pkg::SZ_BYTE: load_val = {{24{ld_byte[0][7]}}, ld_byte[0]};
      mse_pkg::SZ_HALF: load_val = {{16{ld_byte[1][7]}}, ld_byte[1], ld_byte[0]};
      default:          load_val = {ld_byte[3], ld_byte[2], ld_byte[1], ld_byte[0]};
    endcase
    s2_val = s2_load_r ? load_val : s2_alu_r;
  end

  always_comb begin
    out_nxt               = '0;
    out_nxt.jump_taken    = s2_taken_r;
    out_nxt.jump_target   = s2_taken_r ? s2_target_r : 10'd0;
    out_nxt.reg_written   = s2_wr_r;
    out_nxt.written_reg   = s2_wr_r ? s2_dst_r : 5'd0;
    out_nxt.written_value = s2_wr_r ? s2_val : 32'd0;
    out_nxt.mem_fault     = s2_fault_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      wb_v_r  <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_v_r <= accept;
      end
      if (s2_en) begin
        s2_v_r <= s1_v_r;
      end
      if (s3_free) begin
        out_v_r <= s2_v_r;
      end
      if (item_wr) begin
        wb_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_func_r   <= in_item.func;
      s1_kind_r   <= in_item.branch_kind;
      s1_useimm_r <= in_item.use_immediate;
      s1_rs_r     <= in_item.src_reg;
      s1_rt_r     <= in_item.tgt_reg;
      s1_dst_r    <= dst_in;
      s1_imm_r    <= in_item.immediate;
      s1_size_r   <= in_item.access_size;
      s1_target_r <= in_item.branch_target & mse_pkg::TARGET_MASK;
    end
    if (s2_en) begin
      s2_taken_r  <= taken_nxt;
      s2_target_r <= s1_target_r;
      s2_wr_r     <= wr_nxt;
      s2_dst_r    <= s1_dst_r;
      s2_alu_r    <= alu_nxt;
      s2_load_r   <= load_nxt;
      s2_size_r   <= s1_size_r;
      s2_lo_r     <= sum[1:0];
      s2_fault_r  <= fault_nxt;
    end
    if (s3_free) begin
      out_item_r <= out_nxt;
    end
    if (item_wr) begin
      wb_idx_r <= s2_dst_r;
      wb_val_r <= s2_val;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_item_r;

endmodule

`default_nettype wire

// ===== src/mse_checker.sv =====
// Port-level checks on the execute unit, attached by the bind at the end.
// Depends on mse_pkg and assert_macros.svh.
`include "assert_macros.svh"
`default_nettype none

module mse_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_tvalid,
  input wire logic                      in_tready,
  input wire logic [mse_pkg::IN_W-1:0]  in_tdata,
  input wire logic                      out_tvalid,
  input wire logic                      out_tready,
  input wire logic [mse_pkg::OUT_W-1:0] out_tdata
);

  mse_pkg::out_item_t o;
  logic               in_beat;

  assign o       = mse_pkg::out_item_t'(out_tdata);
  assign in_beat = in_tvalid && in_tready && !$isunknown(in_tdata);

  `ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
              out_tvalid && $stable(out_tdata), "result beat changed while stalled")
  `ASSERT_NXT_RAW(a_reset_quiet, clk, !rst_n, !out_tvalid && !in_tready && !in_beat,
                  "beats possible right after reset")
  `ASSERT_IMP(a_fault_alone, clk, rst_n, out_tvalid && o.mem_fault,
              !o.reg_written && !o.jump_taken, "fault beat also writes or jumps")
  `ASSERT_IMP(a_no_write_zero, clk, rst_n, out_tvalid && !o.reg_written,
              o.written_reg == 5'd0 && o.written_value == 32'sd0,
              "unwritten result carries data")
  `ASSERT_IMP(a_no_jump_zero, clk, rst_n, out_tvalid && !o.jump_taken,
              o.jump_target == 10'd0, "untaken result carries a target")

endmodule

bind mips_subset_execute_unit mse_checker u_mse_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
